>>> hw/rtl/mer_pkg.sv
// Shared types and codes for the midpoint ellipse rasterizer.
// Used by mer_core, mer_quad_out and midpoint_ellipse_rasterizer_top; no dependencies.
`timescale 1ns / 1ps

package mer_pkg;

  // Request kinds carried on the input tuser bit.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Stepping engine states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETUP1 = 6'b000010,
    ST_SETUP2 = 6'b000100,
    ST_SETUP3 = 6'b001000,
    ST_FIRST  = 6'b010000,
    ST_SECOND = 6'b100000
  } mer_state_t;

  // Control that goes with a group of four mirrored pixels.
  typedef struct packed {
    logic push;
    logic last;
  } quad_ctl_t;

endpackage

>>> hw/rtl/mer_core.sv
// Stepping engine: setup multipliers, incremental midpoint decision update
// and the four mirrored pixels of the current point. Depends on mer_pkg.
`timescale 1ns / 1ps

module mer_core #(
  parameter int COORD_BITS = 12,
  localparam int AXIS_BITS = COORD_BITS - 1,
  localparam int PIX_BITS  = COORD_BITS + 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             item_valid,
  input  logic                             item_action,
  input  logic [COORD_BITS-1:0]            item_cx,
  input  logic [COORD_BITS-1:0]            item_cy,
  input  logic [AXIS_BITS-1:0]             item_ax,
  input  logic [AXIS_BITS-1:0]             item_ay,
  output logic                             item_take,
  input  logic                             quad_free,
  output mer_pkg::quad_ctl_t               quad_ctl,
  output logic [3:0][PIX_BITS-1:0]         quad_px,
  output logic [3:0][PIX_BITS-1:0]         quad_py
);

  localparam int SQ_BITS   = 2 * AXIS_BITS;
  localparam int CUBE_BITS = 3 * AXIS_BITS;
  localparam int DEC_BITS  = 3 * AXIS_BITS + 7;

  mer_pkg::mer_state_t state_r, state_nxt;

  logic [COORD_BITS-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [AXIS_BITS-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [SQ_BITS-1:0]    a2_r, a2_nxt, b2_r, b2_nxt, ab_r, ab_nxt;
  logic [CUBE_BITS-1:0]  a2b_r, a2b_nxt, b2a_r, b2a_nxt;
  logic [COORD_BITS-1:0] x_r, x_nxt, y_r, y_nxt;

  logic signed [DEC_BITS-1:0] d_r, d_nxt, kd_r, kd_nxt, ka_r, ka_nxt;
  logic signed [DEC_BITS-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [DEC_BITS-1:0] d2i_r, d2i_nxt, kd2i_r, kd2i_nxt, ka2i_r, ka2i_nxt;

  logic signed [DEC_BITS-1:0] a2_s, b2_s, a2b_s, b2a_s;
  logic signed [DEC_BITS-1:0] d_step;
  logic signed [DEC_BITS-1:0] dx1, dy1, kd1, ka1, dx2, dy2, kd2, ka2;
  logic [COORD_BITS-1:0]      x1, y1, x2, y2;
  logic                       dec, cont1, cont2;
  logic                       running, busy, is_start, emit, last_pt;

  logic [PIX_BITS-1:0] px_plus, px_minus, py_plus, py_minus;

  // Zero-extended squares and cubes in the decision width.
  assign a2_s  = DEC_BITS'(a2_r);
  assign b2_s  = DEC_BITS'(b2_r);
  assign a2b_s = DEC_BITS'(a2b_r);
  assign b2a_s = DEC_BITS'(b2a_r);

  // Request acceptance: starts are taken unless setup is in progress,
  // emitting steps also need room for a pixel group.
  assign running   = (state_r == mer_pkg::ST_FIRST) || (state_r == mer_pkg::ST_SECOND);
  assign busy      = (state_r == mer_pkg::ST_SETUP1) || (state_r == mer_pkg::ST_SETUP2) ||
                     (state_r == mer_pkg::ST_SETUP3);
  assign is_start  = (item_action == mer_pkg::ACT_START);
  assign item_take = item_valid && !busy && (is_start || !running || quad_free);
  assign emit      = item_take && !is_start && running;

  // Decision update shared by both halves: add the advance term, and the
  // decrement term as well when the decision is not negative.
  assign dec    = ~d_r[DEC_BITS-1];
  assign d_step = d_r + ka_r + (dec ? kd_r : DEC_BITS'(0));

  // First half: x advances, y may step down.
  assign x1    = x_r + COORD_BITS'(1);
  assign y1    = dec ? (y_r - COORD_BITS'(1)) : y_r;
  assign dx1   = dx_r + b2_s;
  assign dy1   = dec ? (dy_r - a2_s) : dy_r;
  assign kd1   = dec ? (kd_r + (a2_s <<< 2)) : kd_r;
  assign ka1   = ka_r + (b2_s <<< 2);
  assign cont1 = (dx1 <= dy1);

  // Second half: y advances, x may step down.
  assign y2    = y_r + COORD_BITS'(1);
  assign x2    = dec ? (x_r - COORD_BITS'(1)) : x_r;
  assign dy2   = dy_r + a2_s;
  assign dx2   = dec ? (dx_r - b2_s) : dx_r;
  assign kd2   = dec ? (kd_r + (b2_s <<< 2)) : kd_r;
  assign ka2   = ka_r + (a2_s <<< 2);
  assign cont2 = (dy2 <= dx2);

  assign last_pt = (state_r == mer_pkg::ST_SECOND) && !cont2;

  // Mirrored pixels of the current point, before it advances.
  assign px_plus  = PIX_BITS'(ox_r) + PIX_BITS'(x_r);
  assign px_minus = PIX_BITS'(ox_r) - PIX_BITS'(x_r);
  assign py_plus  = PIX_BITS'(oy_r) + PIX_BITS'(y_r);
  assign py_minus = PIX_BITS'(oy_r) - PIX_BITS'(y_r);

  assign quad_px = {px_minus, px_plus, px_minus, px_plus};
  assign quad_py = {py_minus, py_minus, py_plus, py_plus};

  assign quad_ctl.push = emit;
  assign quad_ctl.last = last_pt;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    a2_nxt    = a2_r;
    b2_nxt    = b2_r;
    ab_nxt    = ab_r;
    a2b_nxt   = a2b_r;
    b2a_nxt   = b2a_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    d_nxt     = d_r;
    kd_nxt    = kd_r;
    ka_nxt    = ka_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    d2i_nxt   = d2i_r;
    kd2i_nxt  = kd2i_r;
    ka2i_nxt  = ka2i_r;

    case (state_r)
      mer_pkg::ST_SETUP1: begin
        a2_nxt    = SQ_BITS'(a_r) * SQ_BITS'(a_r);
        b2_nxt    = SQ_BITS'(b_r) * SQ_BITS'(b_r);
        ab_nxt    = SQ_BITS'(a_r) * SQ_BITS'(b_r);
        state_nxt = mer_pkg::ST_SETUP2;
      end
      mer_pkg::ST_SETUP2: begin
        a2b_nxt   = CUBE_BITS'(ab_r) * CUBE_BITS'(a_r);
        b2a_nxt   = CUBE_BITS'(ab_r) * CUBE_BITS'(b_r);
        state_nxt = mer_pkg::ST_SETUP3;
      end
      mer_pkg::ST_SETUP3: begin
        // First half begins at (0, b); second-half start values kept for later.
        x_nxt    = '0;
        y_nxt    = COORD_BITS'(b_r);
        dx_nxt   = '0;
        dy_nxt   = a2b_s;
        d_nxt    = (b2_s <<< 1) + a2_s - (a2b_s <<< 1);
        kd_nxt   = (a2_s <<< 2) - (a2b_s <<< 2);
        ka_nxt   = (b2_s <<< 2) + (b2_s <<< 1);
        d2i_nxt  = (a2_s <<< 1) + b2_s - (b2a_s <<< 1);
        kd2i_nxt = (b2_s <<< 2) - (b2a_s <<< 2);
        ka2i_nxt = (a2_s <<< 2) + (a2_s <<< 1);
        if ((a_r == '0) || (b_r == '0)) begin
          state_nxt = mer_pkg::ST_IDLE;
        end else begin
          state_nxt = mer_pkg::ST_FIRST;
        end
      end
      mer_pkg::ST_FIRST: begin
        if (emit) begin
          if (cont1) begin
            x_nxt  = x1;
            y_nxt  = y1;
            dx_nxt = dx1;
            dy_nxt = dy1;
            d_nxt  = d_step;
            kd_nxt = kd1;
            ka_nxt = ka1;
          end else begin
            // Switch to the second half starting at (a, 0).
            x_nxt     = COORD_BITS'(a_r);
            y_nxt     = '0;
            dx_nxt    = b2a_s;
            dy_nxt    = '0;
            d_nxt     = d2i_r;
            kd_nxt    = kd2i_r;
            ka_nxt    = ka2i_r;
            state_nxt = mer_pkg::ST_SECOND;
          end
        end
      end
      mer_pkg::ST_SECOND: begin
        if (emit) begin
          x_nxt  = x2;
          y_nxt  = y2;
          dx_nxt = dx2;
          dy_nxt = dy2;
          d_nxt  = d_step;
          kd_nxt = kd2;
          ka_nxt = ka2;
          if (!cont2) begin
            state_nxt = mer_pkg::ST_IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    // A start request loads new geometry and abandons any running ellipse.
    if (item_take && is_start) begin
      ox_nxt    = item_cx;
      oy_nxt    = item_cy;
      a_nxt     = item_ax;
      b_nxt     = item_ay;
      state_nxt = mer_pkg::ST_SETUP1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mer_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Geometry and decision registers.
  always_ff @(posedge clk) begin
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    a2_r   <= a2_nxt;
    b2_r   <= b2_nxt;
    ab_r   <= ab_nxt;
    a2b_r  <= a2b_nxt;
    b2a_r  <= b2a_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    d_r    <= d_nxt;
    kd_r   <= kd_nxt;
    ka_r   <= ka_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    d2i_r  <= d2i_nxt;
    kd2i_r <= kd2i_nxt;
    ka2i_r <= ka2i_nxt;
  end

endmodule

>>> hw/rtl/mer_quad_out.sv
// Output serializer: holds one group of four pixels and presents them one
// per cycle on the result stream while out_tready is high. Depends on mer_pkg.
`timescale 1ns / 1ps

module mer_quad_out #(
  parameter int COORD_BITS = 12,
  localparam int PIX_BITS  = COORD_BITS + 2,
  localparam int OUT_W     = ((2 * PIX_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mer_pkg::quad_ctl_t       quad_ctl,
  input  logic [3:0][PIX_BITS-1:0] quad_px,
  input  logic [3:0][PIX_BITS-1:0] quad_py,
  output logic                     quad_free,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_W-1:0]         out_tdata,
  output logic                     out_tlast
);

  localparam logic [1:0] LAST_IDX = 2'd3;

  logic                     valid_r, valid_nxt;
  logic [1:0]               idx_r, idx_nxt;
  logic                     last_r, last_nxt;
  logic [3:0][PIX_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic                     done;

  // The group frees up as its fourth pixel is taken.
  assign done      = valid_r && out_tready && (idx_r == LAST_IDX);
  assign quad_free = !valid_r || done;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    if (quad_ctl.push) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
      last_nxt  = quad_ctl.last;
      px_nxt    = quad_px;
      py_nxt    = quad_py;
    end else if (valid_r && out_tready) begin
      idx_nxt = idx_r + 2'd1;
      if (idx_r == LAST_IDX) begin
        valid_nxt = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Pixel payload.
  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
  end

  // Result stream driven straight from the held group.
  assign out_tvalid = valid_r;
  assign out_tdata  = OUT_W'({py_r[idx_r], px_r[idx_r]});
  assign out_tlast  = last_r && (idx_r == LAST_IDX);

endmodule

>>> hw/rtl/midpoint_ellipse_rasterizer_top.sv
// Top level of the midpoint ellipse rasterizer: input request register,
// stepping engine and output serializer. Depends on mer_pkg, mer_core, mer_quad_out.
`timescale 1ns / 1ps

// Usage:
// The input stream carries requests. in_tuser selects the kind: a start request
// loads centre and semi-axes from in_tdata, a step request emits the next point.
// Each step of a running ellipse produces four pixels on the output stream, one
// per cycle: (cx+x,cy+y), (cx-x,cy+y), (cx+x,cy-y), (cx-x,cy-y). out_tlast marks
// the fourth pixel of the final point. Steps while no ellipse runs emit nothing.
// A step request accepted on the input stream passes the input request register
// and then the pixel group register before out_tvalid rises. The output stream
// carries one pixel per cycle while out_tready is high, and the engine takes the
// next step once the fourth pixel of the held group is taken. A start holds the
// engine for its load and the setup states for the squared and cubed axis products.
// A request is registered on entry, so the next one is accepted while pixels are
// still being delivered. When the receiver stalls, the current pixel holds and
// requests back up through in_tready. Reset clears all valid flags and returns
// the engine to idle; no pixel is pending after reset.
module midpoint_ellipse_rasterizer_top #(
  parameter int COORD_BITS = 12,
  localparam int AXIS_BITS = COORD_BITS - 1,
  localparam int PIX_BITS  = COORD_BITS + 2,
  localparam int IN_W      = ((4 * COORD_BITS - 2 + 7) / 8) * 8,
  localparam int OUT_W     = ((2 * PIX_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // center_x, center_y, semi_axis_x, semi_axis_y, zero pad
  input  logic             in_tuser,   // action
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // pixel_x, pixel_y, zero pad
  output logic             out_tlast   // end_of_ellipse
);

  logic                  item_valid_r, item_valid_nxt;
  logic                  item_action_r;
  logic [COORD_BITS-1:0] item_cx_r, item_cy_r;
  logic [AXIS_BITS-1:0]  item_ax_r, item_ay_r;
  logic                  item_take;
  logic                  in_fire;
  logic                  quad_free;

  mer_pkg::quad_ctl_t       quad_ctl;
  logic [3:0][PIX_BITS-1:0] quad_px, quad_py;

  // Input request register: refilled as soon as the engine takes its request.
  assign in_tready      = !item_valid_r || item_take;
  assign in_fire        = in_tvalid && in_tready;
  assign item_valid_nxt = in_fire || (item_valid_r && !item_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_action_r <= in_tuser;
      item_cx_r     <= in_tdata[COORD_BITS-1:0];
      item_cy_r     <= in_tdata[2*COORD_BITS-1:COORD_BITS];
      item_ax_r     <= in_tdata[2*COORD_BITS+AXIS_BITS-1:2*COORD_BITS];
      item_ay_r     <= in_tdata[2*COORD_BITS+2*AXIS_BITS-1:2*COORD_BITS+AXIS_BITS];
    end
  end

  // Stepping engine.
  mer_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid_r),
    .item_action (item_action_r),
    .item_cx     (item_cx_r),
    .item_cy     (item_cy_r),
    .item_ax     (item_ax_r),
    .item_ay     (item_ay_r),
    .item_take   (item_take),
    .quad_free   (quad_free),
    .quad_ctl    (quad_ctl),
    .quad_px     (quad_px),
    .quad_py     (quad_py)
  );

  // Pixel serializer.
  mer_quad_out #(
    .COORD_BITS(COORD_BITS)
  ) u_quad_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .quad_ctl   (quad_ctl),
    .quad_px    (quad_px),
    .quad_py    (quad_py),
    .quad_free  (quad_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> tb/midpoint_ellipse_rasterizer_top_tb.sv
// Self-checking testbench for midpoint_ellipse_rasterizer_top: directed rows, then random ellipses
// checked pixel by pixel against a behavioral tracer. Depends on mer_pkg and the top-level RTL.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_top_tb;

  localparam int PIX_W       = 14;
  localparam int LIVE_TARGET = 470;
  localparam int CYCLE_LIMIT = 400000;

  // How a request's expected pixels are obtained.
  typedef enum logic [1:0] {
    ROW_PREDICT,  // from the tracer
    ROW_NONE,     // no pixels at all
    ROW_POINT     // the four mirrors of the point typed in the row
  } row_kind_t;

  typedef struct {
    logic             act;
    logic [11:0]      cx;
    logic [11:0]      cy;
    logic [10:0]      ax;
    logic [10:0]      ay;
    row_kind_t        kind;
    int               px;
    int               py;
    bit               plast;
  } ellipse_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             last;
  } pixel_t;

  typedef enum logic [1:0] {TRACE_IDLE, TRACE_FIRST, TRACE_SECOND} trace_phase_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // center_x, center_y, semi_axis_x, semi_axis_y, zero pad
  logic        in_tuser;   // action
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // pixel_x, pixel_y, zero pad
  logic        out_tlast;  // end_of_ellipse

  // Tracer state, a behavioral copy of the stepping engine.
  trace_phase_t trace_phase = TRACE_IDLE;
  longint org_x = 0, org_y = 0, ax_sq = 0, ay_sq = 0;
  longint pt_x = 0, pt_y = 0, err_term = 0, semi_a = 0;

  pixel_t       pixel_q[$];
  ellipse_req_t stim_table[$];
  pixel_t       want;

  int in_gap_pct  = 19;
  int stall_pct   = 19;
  int errors      = 0;
  int live_items  = 0;
  int start_count = 0;
  int step_count  = 0;
  int pixel_count = 0;
  int end_count   = 0;
  int cycle_count = 0;

  midpoint_ellipse_rasterizer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 12 ns clock.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic ellipse_req_t mk_req(logic act, logic [11:0] cx, logic [11:0] cy,
                                          logic [10:0] ax, logic [10:0] ay,
                                          row_kind_t kind, int px, int py, bit plast);
    ellipse_req_t r;
    r.act = act;
    r.cx = cx;
    r.cy = cy;
    r.ax = ax;
    r.ay = ay;
    r.kind = kind;
    r.px = px;
    r.py = py;
    r.plast = plast;
    return r;
  endfunction

  // Queue the four mirrored pixels of point (x,y) around the current origin.
  task automatic push_point(longint x, longint y, bit last);
    pixel_t p;
    p.last = 1'b0;
    p.px = PIX_W'(org_x + x);
    p.py = PIX_W'(org_y + y);
    pixel_q.push_back(p);
    p.px = PIX_W'(org_x - x);
    pixel_q.push_back(p);
    p.px = PIX_W'(org_x + x);
    p.py = PIX_W'(org_y - y);
    pixel_q.push_back(p);
    p.px = PIX_W'(org_x - x);
    p.last = last;
    pixel_q.push_back(p);
  endtask

  // Advance the tracer by one accepted request; queue its pixels when asked to.
  task automatic advance_ellipse(ellipse_req_t r, bit record);
    longint a2, b2, x0, y0;
    bit     last;
    bit     emits;
    a2 = ax_sq;
    b2 = ay_sq;
    x0 = pt_x;
    y0 = pt_y;
    last = 1'b0;
    emits = 1'b0;
    if (r.act == mer_pkg::ACT_START) begin
      org_x = longint'(r.cx);
      org_y = longint'(r.cy);
      semi_a = longint'(r.ax);
      ax_sq = semi_a * semi_a;
      ay_sq = longint'(r.ay) * longint'(r.ay);
      pt_x = 0;
      pt_y = longint'(r.ay);
      err_term = 2 * ay_sq + ax_sq * (1 - 2 * pt_y);
      trace_phase = (r.ax == 0 || r.ay == 0) ? TRACE_IDLE : TRACE_FIRST;
      start_count++;
      live_items++;
    end else if (trace_phase == TRACE_FIRST) begin
      // Upper region: y falls when the midpoint lies outside.
      if (err_term >= 0) begin
        err_term += 4 * a2 * (1 - pt_y);
        pt_y--;
      end
      err_term += b2 * (4 * pt_x + 6);
      pt_x++;
      if (!(b2 * pt_x <= a2 * pt_y)) begin
        pt_x = semi_a;
        pt_y = 0;
        err_term = 2 * a2 + b2 * (1 - 2 * semi_a);
        trace_phase = TRACE_SECOND;
      end
      emits = 1'b1;
    end else if (trace_phase == TRACE_SECOND) begin
      // Lower region, traced up from (a,0).
      if (err_term >= 0) begin
        err_term += 4 * b2 * (1 - pt_x);
        pt_x--;
      end
      err_term += a2 * (4 * pt_y + 6);
      pt_y++;
      if (!(a2 * pt_y <= b2 * pt_x)) begin
        last = 1'b1;
        trace_phase = TRACE_IDLE;
      end
      emits = 1'b1;
    end
    if (emits) begin
      step_count++;
      live_items++;
      if (record) begin
        push_point(x0, y0, last);
      end
    end
  endtask

  // Present one request, wait for the handshake, then queue what it should produce.
  task automatic send_request(ellipse_req_t r);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.act;
    in_tdata  <= {2'b00, r.ay, r.ax, r.cy, r.cx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_ellipse(r, r.kind == ROW_PREDICT);
    if (r.kind == ROW_POINT) begin
      push_point(r.px, r.py, r.plast);
    end
  endtask

  // Receiver backpressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare every delivered pixel with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      pixel_count++;
      if (out_tlast) end_count++;
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel: pixel_x=%0d pixel_y=%0d end_of_ellipse=%0b",
               $signed(out_tdata[13:0]), $signed(out_tdata[27:14]), out_tlast);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (out_tdata[13:0] !== want.px) begin
          $error("pixel_x: expected %0d, got %0d", $signed(want.px), $signed(out_tdata[13:0]));
          errors++;
        end
        if (out_tdata[27:14] !== want.py) begin
          $error("pixel_y: expected %0d, got %0d", $signed(want.py), $signed(out_tdata[27:14]));
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("end_of_ellipse: expected %0b, got %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixels still expected", cycle_count,
               pixel_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned roll;
    int unsigned cap;
    int unsigned n;
    bit          abandon;
    logic [10:0] ax;
    logic [10:0] ay;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = mer_pkg::ACT_START;
    in_tdata   = '0;
    out_tready = 1'b0;

    // Directed rows: unit ellipse at both corners, largest axes, abandoned runs.
    stim_table.push_back(mk_req(mer_pkg::ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,
                                ROW_NONE, 0, 0, 1'b0));
    stim_table.push_back(mk_req(mer_pkg::ACT_START, 12'd0,    12'd0,    11'd1,    11'd1,
                                ROW_NONE, 0, 0, 1'b0));
    stim_table.push_back(mk_req(mer_pkg::ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,
                                ROW_POINT, 0, 1, 1'b0));
    stim_table.push_back(mk_req(mer_pkg::ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,
                                ROW_POINT, 1, 0, 1'b1));
    stim_table.push_back(mk_req(mer_pkg::ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,
                                ROW_NONE, 0, 0, 1'b0));
    stim_table.push_back(mk_req(mer_pkg::ACT_START, 12'd4095, 12'd4095, 11'd1,    11'd1,
                                ROW_NONE, 0, 0, 1'b0));
    stim_table.push_back(mk_req(mer_pkg::ACT_STEP,  12'd4095, 12'd4095, 11'd2047, 11'd2047,
                                ROW_POINT, 0, 1, 1'b0));
    stim_table.push_back(mk_req(mer_pkg::ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,
                                ROW_POINT, 1, 0, 1'b1));
    stim_table.push_back(mk_req(mer_pkg::ACT_START, 12'd0,    12'd0,    11'd2047, 11'd2047,
                                ROW_NONE, 0, 0, 1'b0));
    stim_table.push_back(mk_req(mer_pkg::ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,
                                ROW_POINT, 0, 2047, 1'b0));
    stim_table.push_back(mk_req(mer_pkg::ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,
                                ROW_PREDICT, 0, 0, 1'b0));
    // A start in the middle of a run drops the old ellipse.
    stim_table.push_back(mk_req(mer_pkg::ACT_START, 12'd4095, 12'd0,    11'd2047, 11'd1,
                                ROW_NONE, 0, 0, 1'b0));
    repeat (3) stim_table.push_back(mk_req(mer_pkg::ACT_STEP, 12'd0, 12'd0, 11'd0, 11'd0,
                                           ROW_PREDICT, 0, 0, 1'b0));
    stim_table.push_back(mk_req(mer_pkg::ACT_START, 12'd0,    12'd4095, 11'd1,    11'd2047,
                                ROW_NONE, 0, 0, 1'b0));
    repeat (2) stim_table.push_back(mk_req(mer_pkg::ACT_STEP, 12'd0, 12'd0, 11'd0, 11'd0,
                                           ROW_PREDICT, 0, 0, 1'b0));
    stim_table.push_back(mk_req(mer_pkg::ACT_START, 12'd1234, 12'd2345, 11'd3,    11'd5,
                                ROW_NONE, 0, 0, 1'b0));
    repeat (5) stim_table.push_back(mk_req(mer_pkg::ACT_STEP, 12'd0, 12'd0, 11'd0, 11'd0,
                                           ROW_PREDICT, 0, 0, 1'b0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) send_request(stim_table[i]);

    // Random ellipses: mostly small ones traced to the end, some dropped early.
    while (live_items < LIVE_TARGET) begin
      if (live_items >= 250 && live_items < 330) begin
        in_gap_pct = 0;
        stall_pct  = 0;
      end else begin
        in_gap_pct = 19;
        stall_pct  = 19;
      end
      roll = $urandom_range(99);
      if (roll < 6) begin
        // Stray step with junk geometry.
        send_request(mk_req(mer_pkg::ACT_STEP, 12'($urandom), 12'($urandom),
                            11'($urandom), 11'($urandom), ROW_PREDICT, 0, 0, 1'b0));
      end else begin
        roll = $urandom_range(99);
        if (roll < 80) begin
          ax  = 11'($urandom_range(1, 24));
          ay  = 11'($urandom_range(1, 24));
          cap = 100000;
        end else if (roll < 92) begin
          ax  = 11'($urandom_range(1, 60));
          ay  = 11'($urandom_range(1, 60));
          cap = 100000;
        end else begin
          ax  = 11'($urandom_range(1, 2047));
          ay  = 11'($urandom_range(1, 2047));
          cap = $urandom_range(4, 30);
        end
        abandon = ($urandom_range(99) < 15);
        if (abandon) cap = $urandom_range(0, 6);
        send_request(mk_req(mer_pkg::ACT_START, 12'($urandom), 12'($urandom), ax, ay,
                            ROW_PREDICT, 0, 0, 1'b0));
        n = 0;
        while (trace_phase != TRACE_IDLE && n < cap) begin
          send_request(mk_req(mer_pkg::ACT_STEP, 12'($urandom), 12'($urandom),
                              11'($urandom), 11'($urandom), ROW_PREDICT, 0, 0, 1'b0));
          n++;
        end
        // Steps past the end produce nothing.
        if (trace_phase == TRACE_IDLE) begin
          repeat ($urandom_range(0, 2)) begin
            send_request(mk_req(mer_pkg::ACT_STEP, 12'($urandom), 12'($urandom),
                                11'($urandom), 11'($urandom), ROW_PREDICT, 0, 0, 1'b0));
          end
        end
      end
    end
    in_tvalid <= 1'b0;
    in_gap_pct = 19;
    stall_pct  = 19;

    // Drain, then give the block a few more cycles to show any stray pixel.
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Run covered %0d starts and %0d pixel-producing steps; %0d pixels checked.",
             start_count, step_count, pixel_count);
    $display("%0d ellipses were traced to their end marker.", end_count);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
